// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/bved_pkg.sv =====
package bved_pkg;

    localparam int ALPHABET_SIZE = 16;
    localparam int PATTERN_MAX   = 64;
    localparam int COUNT_WIDTH   = 16;

    // widths (the index widths are derived from the sizes)
    localparam int SYM_W   = 8;
    localparam int SIDX_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int PIDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W   = 7;
    localparam int FIELD_W = 16;

    // commands (tuser of the input stream)
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [2:0] REG_MAX_DISTANCE   = 3'd1;
    localparam logic [2:0] REG_STOP_MODE      = 3'd2;
    localparam logic [2:0] REG_NO_WILDCARDS   = 3'd3;
    localparam logic [2:0] REG_WILDCARD_CODE  = 3'd4;

    typedef logic [PATTERN_MAX-1:0] t_vec;
    typedef logic [COUNT_WIDTH-1:0] t_count;

endpackage

// ===== rtl/core/bitvector_edit_distance.sv =====
// Global edit distance between a loaded pattern and a streamed text, computed
// column by column with the bit-parallel vector method (row 0 carry forced to 1).
//
// Input stream: tuser = command (start / load pattern bit / text symbol),
// tdata = symbol and pattern index, tlast = last text symbol. Only a text
// command yields a result; start and load items are consumed silently.
// Output stream: tdata = distance and consumed count, tlast = run stopped,
// tuser = run aborted on a forbidden wildcard.
// Config: write enable, register index, 8-bit data; the user writes it only
// while idle, which the block itself does not enforce.
// Throughput: one item per cycle when the output does not stall. The column
// update (one PATTERN_MAX-bit add plus bitwise logic) finishes within the
// result stage, so the next column uses the new vectors at once. An input
// item reaches the output through the input register, then the result register.
// Stall: a waiting result holds the result register; start and load items
// still pass, text items wait in the input register until the slot frees.
// Reset (synchronous, active low): registers to defaults, match table and Mv
// cleared, Pv set to all ones, distance set to 1, both stream registers emptied.
`include "assert_macros.svh"

module bitvector_edit_distance (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] symbol, [13:8] pattern_index, [15:14] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    input  logic        s_axis_tlast,   // end_of_text
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] distance, [31:16] consumed
    output logic        m_axis_tuser,   // [0] undefined
    output logic        m_axis_tlast    // stopped
);
    import bved_pkg::*;

    localparam t_count COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // config registers
    logic [LEN_W-1:0] r_pat_len;
    logic [LEN_W-1:0] r_max_dist;
    logic             r_stop_mode;
    logic             r_no_wild;
    logic [SYM_W-1:0] r_wild_code;

    // input register
    logic              r_in_valid;
    logic [1:0]        r_in_cmd;
    logic [SYM_W-1:0]  r_in_sym;
    logic [PIDX_W:0]   r_in_idx;   // one bit wider: 6-bit field vs. PATTERN_MAX
    logic              r_in_last;

    // run state
    t_vec   r_match [ALPHABET_SIZE];
    t_vec   r_pv, n_pv;
    t_vec   r_mv, n_mv;
    t_count r_dist, n_dist;
    t_count r_cons, n_cons;
    logic   r_finished, n_finished;

    // result register
    logic   r_out_valid;
    t_count r_out_dist, n_out_dist;
    t_count r_out_cons, n_out_cons;
    logic   r_out_stop, n_out_stop;
    logic   r_out_undef, n_out_undef;

    logic             emit, out_free, proc_fire, in_xfer;
    logic [LEN_W-1:0] eff_len;
    logic [PIDX_W-1:0] row_idx;
    logic             sym_in_table, sym_is_wild, idx_in_range;
    t_vec             eq, xv, xh, ph, mh, ph_sh;
    t_count           adv_dist;
    logic [31:0]      dist_ext, cons_ext;

    // ---- handshake ----
    assign emit      = r_in_valid && (r_in_cmd == CMD_TEXT) && !r_finished;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign proc_fire = r_in_valid && (!emit || out_free);
    assign s_axis_tready = !r_in_valid || proc_fire;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;

    // ---- config ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len   <= LEN_W'(1);
            r_max_dist  <= LEN_W'(1);
            r_stop_mode <= 1'b0;
            r_no_wild   <= 1'b0;
            r_wild_code <= 8'd254;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PATTERN_LENGTH: r_pat_len   <= i_cfg_wdata[LEN_W-1:0];
                REG_MAX_DISTANCE:   r_max_dist  <= i_cfg_wdata[LEN_W-1:0];
                REG_STOP_MODE:      r_stop_mode <= i_cfg_wdata[0];
                REG_NO_WILDCARDS:   r_no_wild   <= i_cfg_wdata[0];
                REG_WILDCARD_CODE:  r_wild_code <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---- input register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_sym  <= s_axis_tdata[7:0];
            r_in_idx  <= (PIDX_W+1)'(s_axis_tdata[13:8]);
            r_in_last <= s_axis_tlast;
        end
    end

    // ---- column update ----
    always_comb begin
        // length clamped to 1..PATTERN_MAX
        if (r_pat_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(PATTERN_MAX)) begin
            eff_len = LEN_W'(PATTERN_MAX);
        end else begin
            eff_len = r_pat_len;
        end
        row_idx = PIDX_W'(eff_len - LEN_W'(1));

        sym_in_table = {1'b0, r_in_sym} < (SYM_W+1)'(ALPHABET_SIZE);
        sym_is_wild  = (r_in_sym == r_wild_code);
        idx_in_range = r_in_idx < (PIDX_W+1)'(PATTERN_MAX);

        // out-of-table symbols and the wildcard match nothing
        eq = (sym_in_table && !sym_is_wild) ? r_match[r_in_sym[SIDX_W-1:0]] : '0;
        xv = eq | r_mv;
        xh = (((eq & r_pv) + r_pv) ^ r_pv) | eq;
        ph = r_mv | ~(xh | r_pv);
        mh = r_pv & xh;
        ph_sh = {ph[PATTERN_MAX-2:0], 1'b1};  // row 0 carry forced in

        adv_dist = r_dist;
        if (ph[row_idx]) begin
            if (r_dist != COUNT_MAX) adv_dist = r_dist + t_count'(1);
        end else if (mh[row_idx]) begin
            if (r_dist != '0) adv_dist = r_dist - t_count'(1);
        end
    end

    always_comb begin
        n_pv        = r_pv;
        n_mv        = r_mv;
        n_dist      = r_dist;
        n_cons      = r_cons;
        n_finished  = r_finished;
        n_out_dist  = '0;
        n_out_cons  = '0;
        n_out_stop  = 1'b1;
        n_out_undef = 1'b1;
        unique case (r_in_cmd)
            CMD_START: begin
                n_pv       = '1;
                n_mv       = '0;
                n_dist     = t_count'(eff_len);
                n_cons     = '0;
                n_finished = 1'b0;
            end
            CMD_TEXT: begin
                if (!r_finished) begin
                    if (r_no_wild && sym_is_wild) begin
                        // forbidden wildcard: abort, vectors untouched
                        n_finished = 1'b1;
                    end else begin
                        n_pv   = {mh[PATTERN_MAX-2:0], 1'b0} | ~(xv | ph_sh);
                        n_mv   = ph_sh & xv;
                        n_dist = adv_dist;
                        n_cons = (r_cons != COUNT_MAX) ? r_cons + t_count'(1) : r_cons;
                        n_out_stop  = r_in_last || (r_stop_mode &&
                                      (adv_dist <= t_count'(r_max_dist)));
                        n_out_undef = 1'b0;
                        n_out_dist  = adv_dist;
                        n_out_cons  = n_cons;
                        if (n_out_stop) n_finished = 1'b1;
                    end
                end
            end
            default: ;  // load handled on the table, unknown command ignored
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv       <= '1;
            r_mv       <= '0;
            r_dist     <= t_count'(1);
            r_cons     <= '0;
            r_finished <= 1'b0;
        end else if (proc_fire) begin
            r_pv       <= n_pv;
            r_mv       <= n_mv;
            r_dist     <= n_dist;
            r_cons     <= n_cons;
            r_finished <= n_finished;
        end
    end

    // match table: cleared by reset and start, at most one bit set per load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (proc_fire && r_in_cmd == CMD_START)) begin
            for (int k = 0; k < ALPHABET_SIZE; k++) begin
                r_match[k] <= '0;
            end
        end else if (proc_fire && r_in_cmd == CMD_LOAD && sym_in_table && idx_in_range) begin
            r_match[r_in_sym[SIDX_W-1:0]] <= r_match[r_in_sym[SIDX_W-1:0]] |
                                             (t_vec'(1) << r_in_idx[PIDX_W-1:0]);
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && emit) begin
            r_out_dist  <= n_out_dist;
            r_out_cons  <= n_out_cons;
            r_out_stop  <= n_out_stop;
            r_out_undef <= n_out_undef;
        end
    end

    assign dist_ext      = 32'(r_out_dist);
    assign cons_ext      = 32'(r_out_cons);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {cons_ext[FIELD_W-1:0], dist_ext[FIELD_W-1:0]};
    assign m_axis_tlast  = r_out_stop;
    assign m_axis_tuser  = r_out_undef;

    // ---- checks ----
    `ASSERT_IMPL(a_undef_stops, i_clk, i_rst_n, r_out_valid && r_out_undef, r_out_stop)
    `ASSERT_IMPL(a_undef_zero, i_clk, i_rst_n, r_out_valid && r_out_undef,
                 r_out_dist == '0 && r_out_cons == '0)
    `ASSERT_NEXT(a_stop_finishes, i_clk, i_rst_n, proc_fire && emit && n_out_stop, r_finished)
    `ASSERT_IMPL(a_no_result_after_end, i_clk, i_rst_n,
                 r_in_valid && r_finished, !emit)

endmodule
